// ===== rtl/core/rnlb_pkg.sv =====
// Package for the NACK list builder: types, codes and sizing constants.
// No dependencies; used by rnlb_entry_ram and rtcp_nack_list_builder_unit.
package rnlb_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int SEQ_W       = 16;
	localparam int MASK_W      = 16;
	localparam int WORD_W      = 32;
	localparam int TB_W        = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int HDR_BYTES   = 12;
	localparam int SSRC_WORDS  = 2;

	localparam logic [WORD_W-1:0] HDR_BASE = 32'h81CD_0000;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_BUILD  = 1'b1;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_WORD   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_REPORTER_SSRC = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIA_SSRC    = 1'b1;

	typedef struct packed {
		logic             op;
		logic [SEQ_W-1:0] seq_number;
	} in_item_t;

	typedef struct packed {
		logic              kind;
		logic              accepted;
		logic [WORD_W-1:0] packet_word;
		logic [TB_W-1:0]   total_bytes;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  id;
		logic [MASK_W-1:0] mask;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} ram_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} ram_rd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADD,
		ST_RESP,
		ST_HDR,
		ST_SSRC_R,
		ST_SSRC_M,
		ST_ENTRY
	} state_e;

endpackage

// ===== rtl/core/rnlb_entry_ram.sv =====
// Entry table: one write port, one read port, registered read data.
// Depends on rnlb_pkg for the entry layout and port structs.
module rnlb_entry_ram
	import rnlb_pkg::*;
(
	input  logic    clk,
	input  ram_wr_t wr,
	input  ram_rd_t rd,
	output entry_t  rd_data
);

	entry_t mem [MAX_ENTRIES];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/rtcp_nack_list_builder_unit.sv =====
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_stall   | in_item  (op, seq_number)
// out     | out | out_valid / out_stall | out_item (kind, accepted, packet_word, total_bytes, last)
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item at a time. An append reads one entry per cycle from the entry RAM,
// in order until an entry equals or absorbs the number; if none does, it opens
// an entry or is rejected. A build sends 3 + count words, one per cycle while out_stall
// is low. The registered read data of the entry RAM sets the scan pace.
// Reset clears count, config and control; entries beyond the count are never read.
// An output register holds a result under out_stall; the sequencer waits on it.
// Depends on rnlb_pkg and rnlb_entry_ram.
module rtcp_nack_list_builder_unit
	import rnlb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	state_e state_q, state_nxt;

	logic [WORD_W-1:0] reporter_ssrc_q, media_ssrc_q;
	logic [CNT_W-1:0]  cnt_q, cnt_nxt;
	logic [IDX_W-1:0]  idx_q, idx_nxt;
	logic [SEQ_W-1:0]  seq_q;
	logic              acc_q, acc_nxt;

	logic      out_valid_q;
	out_item_t out_item_q;
	logic      emit;
	out_item_t emit_item;
	logic      out_free;

	ram_wr_t ram_wr;
	ram_rd_t ram_rd;
	entry_t  rd_data;

	logic              in_fire;
	logic              hit_eq, hit_rng, idx_last;
	logic [SEQ_W:0]    id_top;
	logic [SEQ_W-1:0]  diff;
	logic [31:0]       bytes_full;
	logic [TB_W-1:0]   total_bytes;
	logic [SEQ_W-1:0]  hdr_len;

	rnlb_entry_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd      (ram_rd),
		.rd_data (rd_data)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// plain unsigned compares, no 16-bit wrap
	assign id_top   = {1'b0, rd_data.id} + (SEQ_W+1)'(16);
	assign hit_eq   = (seq_q == rd_data.id);
	assign hit_rng  = (seq_q > rd_data.id) && ({1'b0, seq_q} <= id_top);
	assign diff     = seq_q - rd_data.id - SEQ_W'(1);
	assign idx_last = (CNT_W'(idx_q) + CNT_W'(1) == cnt_q);

	assign bytes_full  = 32'(HDR_BYTES) + (32'(cnt_q) << 2);
	assign total_bytes = bytes_full[TB_W-1:0];
	assign hdr_len     = SEQ_W'(SSRC_WORDS) + SEQ_W'(cnt_q);

	always_comb begin
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		idx_nxt   = idx_q;
		acc_nxt   = acc_q;
		emit      = 1'b0;
		emit_item = '0;
		ram_wr    = '0;
		ram_rd    = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					idx_nxt = '0;
					if (in_item.op == OP_BUILD) begin
						state_nxt = ST_HDR;
					end else if (cnt_q == '0) begin
						state_nxt = ST_ADD;
					end else begin
						ram_rd.en   = 1'b1;
						ram_rd.addr = '0;
						state_nxt   = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit_eq) begin
					acc_nxt   = 1'b1;
					state_nxt = ST_RESP;
				end else if (hit_rng) begin
					ram_wr.en        = 1'b1;
					ram_wr.addr      = idx_q;
					ram_wr.data.id   = rd_data.id;
					ram_wr.data.mask = rd_data.mask | (MASK_W'(1) << diff[3:0]);
					acc_nxt          = 1'b1;
					state_nxt        = ST_RESP;
				end else if (idx_last) begin
					state_nxt = ST_ADD;
				end else begin
					idx_nxt     = idx_q + IDX_W'(1);
					ram_rd.en   = 1'b1;
					ram_rd.addr = idx_nxt;
				end
			end
			ST_ADD: begin
				// a slot may still hold stale data, so write it whole with a zero mask
				if (cnt_q < CNT_W'(MAX_ENTRIES)) begin
					ram_wr.en        = 1'b1;
					ram_wr.addr      = cnt_q[IDX_W-1:0];
					ram_wr.data.id   = seq_q;
					ram_wr.data.mask = '0;
					cnt_nxt          = cnt_q + CNT_W'(1);
					acc_nxt          = 1'b1;
				end else begin
					acc_nxt = 1'b0;
				end
				state_nxt = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					emit               = 1'b1;
					emit_item.kind     = KIND_STATUS;
					emit_item.accepted = acc_q;
					emit_item.last     = 1'b1;
					state_nxt          = ST_IDLE;
				end
			end
			ST_HDR: begin
				if (out_free) begin
					emit                  = 1'b1;
					emit_item.kind        = KIND_WORD;
					emit_item.packet_word = HDR_BASE | {16'h0, hdr_len};
					emit_item.total_bytes = total_bytes;
					state_nxt             = ST_SSRC_R;
				end
			end
			ST_SSRC_R: begin
				if (out_free) begin
					emit                  = 1'b1;
					emit_item.kind        = KIND_WORD;
					emit_item.packet_word = reporter_ssrc_q;
					emit_item.total_bytes = total_bytes;
					state_nxt             = ST_SSRC_M;
				end
			end
			ST_SSRC_M: begin
				if (out_free) begin
					emit                  = 1'b1;
					emit_item.kind        = KIND_WORD;
					emit_item.packet_word = media_ssrc_q;
					emit_item.total_bytes = total_bytes;
					emit_item.last        = (cnt_q == '0);
					if (cnt_q == '0) begin
						state_nxt = ST_IDLE;
					end else begin
						ram_rd.en   = 1'b1;
						ram_rd.addr = '0;
						idx_nxt     = '0;
						state_nxt   = ST_ENTRY;
					end
				end
			end
			ST_ENTRY: begin
				// rd_data only reloads on a read, so it holds under a stall
				if (out_free) begin
					emit                  = 1'b1;
					emit_item.kind        = KIND_WORD;
					emit_item.packet_word = {rd_data.id, rd_data.mask};
					emit_item.total_bytes = total_bytes;
					emit_item.last        = idx_last;
					if (idx_last) begin
						state_nxt = ST_IDLE;
					end else begin
						idx_nxt     = idx_q + IDX_W'(1);
						ram_rd.en   = 1'b1;
						ram_rd.addr = idx_nxt;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			acc_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			idx_q   <= idx_nxt;
			acc_q   <= acc_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			seq_q <= in_item.seq_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reporter_ssrc_q <= '0;
			media_ssrc_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REPORTER_SSRC: reporter_ssrc_q <= cfg_data;
				REG_MEDIA_SSRC:    media_ssrc_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_q <= emit_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above table size");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("entry count moved by other than one");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_wr.en && ram_rd.en))
		else $error("entry RAM read and write in the same cycle");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result loaded over an unread output item");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for rtcp_nack_list_builder_unit: NACK append and packet build items.
// It predicts each result from its own copy of the entry table and the two SSRC registers.
// Depends on rnlb_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module testbench;
	import rnlb_pkg::*;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_item   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data  = '0;

	rtcp_nack_list_builder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted block state
	logic [SEQ_W-1:0]  tbl_ids   [MAX_ENTRIES];
	logic [MASK_W-1:0] tbl_masks [MAX_ENTRIES] = '{default: '0};
	int                tbl_count = 0;
	logic [WORD_W-1:0] ssrc_reporter = '0;
	logic [WORD_W-1:0] ssrc_media    = '0;

	in_item_t  pending_items[$];
	out_item_t expected_results[$];
	int        error_count = 0;
	bit        idling_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// Apply one accepted item to the table copy and queue the results it causes.
	task automatic apply_nack_item(input in_item_t it);
		out_item_t        r;
		bit               hit;
		int               id;
		int               sq;
		int               n;
		logic [TB_W-1:0]  bytes;
		if (it.op == OP_APPEND) begin
			hit = 1'b0;
			sq  = it.seq_number;
			for (int i = 0; i < tbl_count && !hit; i++) begin
				id = tbl_ids[i];
				if (sq == id) begin
					hit = 1'b1;
				end else if (sq > id && sq <= id + 16) begin
					// no 16-bit wrap: an ID near the top never absorbs small numbers
					tbl_masks[i][sq - 1 - id] = 1'b1;
					hit = 1'b1;
				end
			end
			if (!hit && tbl_count < MAX_ENTRIES) begin
				tbl_ids[tbl_count] = it.seq_number;
				tbl_count++;
				hit = 1'b1;
			end
			r          = '0;
			r.kind     = KIND_STATUS;
			r.accepted = hit;
			r.last     = 1'b1;
			expected_results.push_back(r);
		end else begin
			n     = tbl_count;
			bytes = TB_W'(HDR_BYTES + 4 * n);
			for (int w = 0; w < 3 + n; w++) begin
				r             = '0;
				r.kind        = KIND_WORD;
				r.total_bytes = bytes;
				r.last        = (w == 2 + n);
				if (w == 0)
					r.packet_word = HDR_BASE | WORD_W'((SSRC_WORDS + n) & 16'hFFFF);
				else if (w == 1)
					r.packet_word = ssrc_reporter;
				else if (w == 2)
					r.packet_word = ssrc_media;
				else
					r.packet_word = {tbl_ids[w - 3], tbl_masks[w - 3]};
				expected_results.push_back(r);
			end
		end
	endtask

	// driver
	int gap_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				apply_nack_item(in_item);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (idling_on && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(0, 7);
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_item  <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int stall_left = 0;
	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					flag_error($sformatf("unexpected result %h", out_item));
				end else begin
					want = expected_results.pop_front();
					check_field("kind", out_item.kind, want.kind);
					check_field("accepted", out_item.accepted, want.accepted);
					check_field("packet_word", out_item.packet_word, want.packet_word);
					check_field("total_bytes", out_item.total_bytes, want.total_bytes);
					check_field("last", out_item.last, want.last);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 7);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_REPORTER_SSRC)
			ssrc_reporter = val;
		else if (idx == REG_MEDIA_SSRC)
			ssrc_media = val;
	endtask

	task automatic queue_item(input logic op, input int seq);
		in_item_t it;
		it.op         = op;
		it.seq_number = SEQ_W'(seq);
		pending_items.push_back(it);
	endtask

	// sender holds off until every item is out and every result is back;
	// sampled mid-cycle so the driver's updates at the edge have settled
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Some builds; appends mostly next to a known ID so masks fill, the rest anywhere.
	task automatic queue_random(input int count);
		int base;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 5) == 0) begin
				queue_item(OP_BUILD, $urandom_range(0, 65535));
			end else if (tbl_count > 0 && $urandom_range(0, 9) < 6) begin
				base = tbl_ids[$urandom_range(0, tbl_count - 1)];
				queue_item(OP_APPEND, base + $urandom_range(0, 16));
			end else begin
				queue_item(OP_APPEND, $urandom_range(0, 65535));
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(REG_REPORTER_SSRC, '0);
		write_reg(REG_MEDIA_SSRC, '1);

		// empty table, equal to ID, mask bits 0 and 15, edges of the number range
		queue_item(OP_BUILD, 0);
		queue_item(OP_APPEND, 0);
		queue_item(OP_APPEND, 0);
		queue_item(OP_APPEND, 1);
		queue_item(OP_APPEND, 16);
		queue_item(OP_APPEND, 17);
		queue_item(OP_APPEND, 65535);
		queue_item(OP_BUILD, 65535);
		queue_item(OP_BUILD, 0);
		// fill the table, then a rejected number, one absorbed when full, full build
		for (int k = 0; k < MAX_ENTRIES - 3; k++)
			queue_item(OP_APPEND, 1000 + 20 * k);
		queue_item(OP_APPEND, 50000);
		queue_item(OP_APPEND, 1005);
		queue_item(OP_BUILD, 0);
		wait_drained();

		write_reg(REG_REPORTER_SSRC, $urandom());
		write_reg(REG_MEDIA_SSRC, $urandom());
		queue_random(150);
		wait_drained();

		write_reg(REG_REPORTER_SSRC, '1);
		write_reg(REG_MEDIA_SSRC, '0);
		queue_random(150);
		wait_drained();

		write_reg(REG_REPORTER_SSRC, $urandom());
		write_reg(REG_MEDIA_SSRC, $urandom());
		idling_on = 1'b0;
		queue_random(160);
		wait_drained();
		repeat (20) @(posedge clk);

		if (expected_results.size() != 0)
			flag_error($sformatf("%0d results never came", expected_results.size()));

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
